FILE: rtl/core/tclt_pkg.sv
// ----------------------------------------------------------------------------
// Touch contact tracker package
// Shared types, constants and codes for the touch contact tracker.
// ----------------------------------------------------------------------------
package tclt_pkg;

    localparam int MAX_CONTACTS = 16;
    localparam int IDX_W        = (MAX_CONTACTS > 1) ? $clog2(MAX_CONTACTS) : 1;
    localparam int CNT_W        = $clog2(MAX_CONTACTS + 1);

    localparam logic [1:0] OP_FRAME = 2'd0;
    localparam logic [1:0] OP_POINT = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    localparam logic [1:0] PHASE_NEW     = 2'd0;
    localparam logic [1:0] PHASE_MOVED   = 2'd1;
    localparam logic [1:0] PHASE_MISSING = 2'd2;

    localparam logic [1:0] ACT_DOWN   = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_UP     = 2'd2;

    localparam logic [1:0] CFG_LEFT   = 2'd0;
    localparam logic [1:0] CFG_RIGHT  = 2'd1;
    localparam logic [1:0] CFG_TOP    = 2'd2;
    localparam logic [1:0] CFG_BOTTOM = 2'd3;

    localparam logic signed [15:0] RESET_LEFT   = 16'sd0;
    localparam logic signed [15:0] RESET_RIGHT  = 16'sd1919;
    localparam logic signed [15:0] RESET_TOP    = 16'sd0;
    localparam logic signed [15:0] RESET_BOTTOM = 16'sd1079;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [31:0]        touch_id;
        logic signed [15:0] pixel_x;
        logic signed [15:0] pixel_y;
    } in_item_t;

    typedef struct packed {
        logic [7:0]         pointer_id;
        logic signed [15:0] report_x;
        logic signed [15:0] report_y;
        logic [1:0]         action;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [31:0]        ident;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic [1:0]         phase;
        logic               sent_down;
        logic               sent_up;
    } entry_t;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] right;
        logic signed [15:0] top;
        logic signed [15:0] bottom;
    } bounds_t;

    typedef struct packed {
        logic             step;
        logic             push;
        logic [IDX_W-1:0] tail_idx;
        logic             append;
        logic [IDX_W-1:0] app_idx;
    } cell_ctrl_t;

    typedef struct packed {
        entry_t     entry;
        logic       keep;
        logic       match;
        logic       rep_valid;
        logic [1:0] action;
    } head_res_t;

endpackage

FILE: rtl/core/tclt_cell.sv
// ----------------------------------------------------------------------------
// Contact table cell
// Holds one table entry and takes its neighbor's entry, the processed head
// entry or a newly appended entry as the controller directs.
// ----------------------------------------------------------------------------
module tclt_cell
(
    input  logic                      clk,
    input  logic [tclt_pkg::IDX_W-1:0] cell_idx,
    input  tclt_pkg::cell_ctrl_t      ctrl,
    input  tclt_pkg::entry_t          neighbor,
    input  tclt_pkg::entry_t          head_proc,
    input  tclt_pkg::entry_t          app_entry,
    output tclt_pkg::entry_t          entry
);
    import tclt_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.step)
        begin
            if (cell_idx < ctrl.tail_idx)
            begin
                entry_next = neighbor;
            end
            else if (cell_idx == ctrl.tail_idx && ctrl.push)
            begin
                entry_next = head_proc;
            end
        end
        else if (ctrl.append && cell_idx == ctrl.app_idx)
        begin
            entry_next = app_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;

endmodule

FILE: rtl/core/tclt_head.sv
// ----------------------------------------------------------------------------
// Table head processor
// Applies the current request to the entry at the head of the table and
// decides whether it is kept, whether it matches and what it reports.
// ----------------------------------------------------------------------------
module tclt_head
(
    input  tclt_pkg::entry_t    entry,
    input  logic [1:0]          opcode,
    input  logic [31:0]         touch_id,
    input  logic signed [15:0]  pixel_x,
    input  logic signed [15:0]  pixel_y,
    input  logic                found,
    input  tclt_pkg::bounds_t   bounds,
    output tclt_pkg::head_res_t res
);
    import tclt_pkg::*;

    logic in_bounds;

    assign in_bounds = (entry.x >= bounds.left) && (entry.x <= bounds.right) &&
                       (entry.y >= bounds.top) && (entry.y <= bounds.bottom);

    always_comb
    begin
        res           = '0;
        res.entry     = entry;
        res.keep      = 1'b1;
        res.action    = ACT_DOWN;
        unique case (opcode)
            OP_FRAME:
            begin
                res.keep        = (entry.phase != PHASE_MISSING);
                res.entry.phase = PHASE_MISSING;
            end
            OP_POINT:
            begin
                if (!found && entry.ident == touch_id)
                begin
                    res.match       = 1'b1;
                    res.entry.x     = pixel_x;
                    res.entry.y     = pixel_y;
                    res.entry.phase = PHASE_MOVED;
                end
            end
            OP_TICK:
            begin
                if (in_bounds)
                begin
                    if (!entry.sent_down &&
                        (entry.phase == PHASE_NEW || entry.phase == PHASE_MOVED))
                    begin
                        res.rep_valid       = 1'b1;
                        res.action          = ACT_DOWN;
                        res.entry.phase     = PHASE_MOVED;
                        res.entry.sent_down = 1'b1;
                    end
                    else if (entry.phase == PHASE_MOVED)
                    begin
                        res.rep_valid = 1'b1;
                        res.action    = ACT_UPDATE;
                    end
                    else if (!entry.sent_up && entry.phase == PHASE_MISSING)
                    begin
                        res.rep_valid     = 1'b1;
                        res.action        = ACT_UP;
                        res.entry.sent_up = 1'b1;
                    end
                end
            end
            default:
            begin
                res.keep = 1'b1;
            end
        endcase
    end

endmodule

FILE: rtl/core/touch_contact_lifecycle_tracker.sv
// ----------------------------------------------------------------------------
// Touch contact lifecycle tracker
// Keeps an ordered table of touch contacts in a row of cells that works as a
// rotating queue, and reports down, update and up events on inject ticks.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake             Payload
//  in       request    in_valid / in_ready   in_data (opcode, id, x, y)
//  out      report     out_valid / out_ready out_data (id, x, y, action, last)
//  cfg      write      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Every request is taken in the idle state. The queue of cells then rotates
// its entries once past the head processor, one entry per step, and a final
// step closes the walk. A touch point then passes the append state and an
// inject tick the flush state; an unused opcode is only taken in idle.
// Reset empties the table and loads the default screen bounds.
// A stalled report output holds the rotation and the final report of a tick.
// ----------------------------------------------------------------------------
module touch_contact_lifecycle_tracker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  tclt_pkg::in_item_t  in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output tclt_pkg::out_item_t out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [1:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import tclt_pkg::*;

    typedef enum logic [3:0]
    {
        S_IDLE   = 4'b0001,
        S_WALK   = 4'b0010,
        S_APPEND = 4'b0100,
        S_FLUSH  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    bounds_t            bounds_reg, bounds_next;
    logic [1:0]         op_reg, op_next;
    logic [31:0]        id_reg, id_next;
    logic signed [15:0] x_reg, x_next;
    logic signed [15:0] y_reg, y_next;
    logic [CNT_W-1:0]   len_reg, len_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic               found_reg, found_next;
    logic               pend_valid_reg, pend_valid_next;
    out_item_t          pend_reg, pend_next;
    logic               out_valid_reg, out_valid_next;
    out_item_t          out_reg, out_next;

    entry_t             cells [MAX_CONTACTS];
    entry_t             app_entry;
    cell_ctrl_t         ctrl;
    head_res_t          head;
    out_item_t          rep;
    logic               out_free;
    logic               stall;
    logic [CNT_W-1:0]   tail_len;

    tclt_head u_head
    (
        .entry    (cells[0]),
        .opcode   (op_reg),
        .touch_id (id_reg),
        .pixel_x  (x_reg),
        .pixel_y  (y_reg),
        .found    (found_reg),
        .bounds   (bounds_reg),
        .res      (head)
    );

    genvar gi;
    generate
        for (gi = 0; gi < MAX_CONTACTS; gi++)
        begin : g_cell
            if (gi < MAX_CONTACTS - 1)
            begin : g_mid
                tclt_cell u_cell
                (
                    .clk       (clk),
                    .cell_idx  (IDX_W'(gi)),
                    .ctrl      (ctrl),
                    .neighbor  (cells[gi + 1]),
                    .head_proc (head.entry),
                    .app_entry (app_entry),
                    .entry     (cells[gi])
                );
            end
            else
            begin : g_end
                tclt_cell u_cell
                (
                    .clk       (clk),
                    .cell_idx  (IDX_W'(gi)),
                    .ctrl      (ctrl),
                    .neighbor  (head.entry),
                    .head_proc (head.entry),
                    .app_entry (app_entry),
                    .entry     (cells[gi])
                );
            end
        end
    endgenerate

    always_comb
    begin
        app_entry.ident     = id_reg;
        app_entry.x         = x_reg;
        app_entry.y         = y_reg;
        app_entry.phase     = PHASE_NEW;
        app_entry.sent_down = 1'b0;
        app_entry.sent_up   = 1'b0;
    end

    assign rep.pointer_id = head.entry.ident[7:0];
    assign rep.report_x   = head.entry.x;
    assign rep.report_y   = head.entry.y;
    assign rep.action     = head.action;
    assign rep.last       = 1'b0;

    assign out_free = !out_valid_reg || out_ready;
    assign stall    = head.rep_valid && pend_valid_reg && !out_free;
    assign tail_len = len_reg - CNT_W'(1);

    assign in_ready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    always_comb
    begin
        state_next      = state_reg;
        bounds_next     = bounds_reg;
        op_next         = op_reg;
        id_next         = id_reg;
        x_next          = x_reg;
        y_next          = y_reg;
        len_next        = len_reg;
        rem_next        = rem_reg;
        found_next      = found_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_next        = out_reg;
        ctrl            = '0;
        ctrl.tail_idx   = tail_len[IDX_W-1:0];
        ctrl.app_idx    = len_reg[IDX_W-1:0];

        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LEFT:   bounds_next.left   = cfg_data;
                CFG_RIGHT:  bounds_next.right  = cfg_data;
                CFG_TOP:    bounds_next.top    = cfg_data;
                CFG_BOTTOM: bounds_next.bottom = cfg_data;
                default:    bounds_next.left   = bounds_reg.left;
            endcase
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op_next    = in_data.opcode;
                    id_next    = in_data.touch_id;
                    x_next     = in_data.pixel_x;
                    y_next     = in_data.pixel_y;
                    rem_next   = len_reg;
                    found_next = 1'b0;
                    if (in_data.opcode == OP_FRAME || in_data.opcode == OP_POINT ||
                        in_data.opcode == OP_TICK)
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (rem_reg == '0)
                begin
                    if (op_reg == OP_POINT)
                    begin
                        state_next = S_APPEND;
                    end
                    else if (op_reg == OP_TICK)
                    begin
                        state_next = S_FLUSH;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else if (!stall)
                begin
                    ctrl.step = 1'b1;
                    ctrl.push = head.keep;
                    rem_next  = rem_reg - CNT_W'(1);
                    if (!head.keep)
                    begin
                        len_next = len_reg - CNT_W'(1);
                    end
                    if (head.match)
                    begin
                        found_next = 1'b1;
                    end
                    if (head.rep_valid)
                    begin
                        pend_next       = rep;
                        pend_valid_next = 1'b1;
                        if (pend_valid_reg)
                        begin
                            out_next       = pend_reg;
                            out_next.last  = 1'b0;
                            out_valid_next = 1'b1;
                        end
                    end
                end
            end
            S_APPEND:
            begin
                if (!found_reg && len_reg < CNT_W'(MAX_CONTACTS))
                begin
                    ctrl.append = 1'b1;
                    len_next    = len_reg + CNT_W'(1);
                end
                state_next = S_IDLE;
            end
            S_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = S_IDLE;
                end
                else if (out_free)
                begin
                    out_next        = pend_reg;
                    out_next.last   = 1'b1;
                    out_valid_next  = 1'b1;
                    pend_valid_next = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            bounds_reg.left   <= RESET_LEFT;
            bounds_reg.right  <= RESET_RIGHT;
            bounds_reg.top    <= RESET_TOP;
            bounds_reg.bottom <= RESET_BOTTOM;
            len_reg           <= '0;
            rem_reg           <= '0;
            found_reg         <= 1'b0;
            pend_valid_reg    <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            bounds_reg     <= bounds_next;
            len_reg        <= len_next;
            rem_reg        <= rem_next;
            found_reg      <= found_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        id_reg   <= id_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        pend_reg <= pend_next;
        out_reg  <= out_next;
    end

endmodule
